// File: rtl/core/fpm_pkg.sv
package fpm_pkg;

    localparam logic [1:0] RND_NEAREST_EVEN = 2'd0;
    localparam logic [1:0] RND_TOWARD_ZERO  = 2'd1;
    localparam logic [1:0] RND_TOWARD_POS   = 2'd2;
    localparam logic [1:0] RND_TOWARD_NEG   = 2'd3;

    localparam logic [31:0] DEFAULT_NAN = 32'hffc00000;
    localparam logic [31:0] QUIET_BIT   = 32'h00400000;
    localparam logic [30:0] INF_MAG     = 31'h7f800000;
    localparam logic [30:0] MAX_MAG     = 31'h7f7fffff;

    // Stage 1 to stage 2: unpacked operands and the special-case verdict.
    typedef struct packed {
        logic              special;
        logic [31:0]       special_val;
        logic              sign;
        logic signed [9:0] exp_sum;
        logic [23:0]       sig_a;
        logic [23:0]       sig_b;
        logic [1:0]        mode;
    } fpm_unp_t;

    // Stage 2 to stage 3: raw product.
    typedef struct packed {
        logic              special;
        logic [31:0]       special_val;
        logic              sign;
        logic signed [9:0] exp_sum;
        logic [47:0]       prod;
        logic [1:0]        mode;
    } fpm_mul_t;

    // Stage 3 to stage 4: normalized significand ready for rounding.
    typedef struct packed {
        logic              special;
        logic [31:0]       special_val;
        logic              sign;
        logic              ovf;
        logic [7:0]        exp_field;
        logic [23:0]       kept;
        logic [23:0]       rem;
        logic [1:0]        mode;
    } fpm_nrm_t;

    function automatic logic [31:0] fpm_overflow(input logic sign, input logic [1:0] mode);
        logic to_inf;
        begin
            case (mode)
                RND_NEAREST_EVEN: to_inf = 1'b1;
                RND_TOWARD_ZERO:  to_inf = 1'b0;
                RND_TOWARD_POS:   to_inf = ~sign;
                RND_TOWARD_NEG:   to_inf = sign;
                default:          to_inf = 1'b1;
            endcase
            fpm_overflow = {sign, to_inf ? INF_MAG : MAX_MAG};
        end
    endfunction

endpackage

// File: rtl/core/fp32_multiplier.sv
// IEEE-754 single-precision multiplier with gradual underflow and four rounding
// directions chosen by rounding_mode (0 nearest even, 1 toward zero, 2 toward plus
// infinity, 3 toward minus infinity). It is a four-stage pipeline: unpack and special
// case detection, the 24x24 significand multiply, normalization with denormalizing
// shift, and rounding into the output register. One item is accepted every cycle
// while the pipe advances; the whole pipe advances when the output slot is empty or
// being taken, so a stall holds every stage in place. NaN operands come back quieted
// (operand a wins), zero times infinity gives 0xFFC00000. Write rounding_mode only
// while the pipe is empty.
module fp32_multiplier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,   // rounding_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // [31:0] operand_a, [63:32] operand_b
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata        // [31:0] product
);
    import fpm_pkg::*;

    logic [1:0]  mode_reg;
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        advance;
    fpm_unp_t    unp_next, unp_reg;
    fpm_mul_t    mul_reg;
    fpm_nrm_t    nrm_next, nrm_reg;
    logic [31:0] res_next, res_reg;

    // The pipe moves as a whole whenever the output slot can take a new product.
    assign advance  = ~v4_reg | m_tready;
    assign s_tready = advance;
    assign m_tvalid = v4_reg;
    assign m_tdata  = res_reg;

    fpm_unpack u_unpack (
        .operand_a (s_tdata[31:0]),
        .operand_b (s_tdata[63:32]),
        .mode      (mode_reg),
        .unp       (unp_next)
    );

    fpm_normalize u_normalize (
        .mul (mul_reg),
        .nrm (nrm_next)
    );

    fpm_round u_round (
        .nrm    (nrm_reg),
        .result (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= RND_NEAREST_EVEN;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (advance) begin
                v1_reg <= s_tvalid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            unp_reg             <= unp_next;
            mul_reg.special     <= unp_reg.special;
            mul_reg.special_val <= unp_reg.special_val;
            mul_reg.sign        <= unp_reg.sign;
            mul_reg.exp_sum     <= unp_reg.exp_sum;
            mul_reg.mode        <= unp_reg.mode;
            mul_reg.prod        <= unp_reg.sig_a * unp_reg.sig_b;
            nrm_reg             <= nrm_next;
            res_reg             <= res_next;
        end
    end

`ifndef SYNTH
    // A held product must not change while the consumer stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("held product changed");

    // An accepted item is not lost: it reaches the output when nothing stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid)
        else $error("item lost in pipe");

    // Input side is open whenever the output slot is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("pipe stalled with empty output");
`endif

endmodule

// File: rtl/core/fpm_unpack.sv
module fpm_unpack (
    input  logic [31:0]       operand_a,
    input  logic [31:0]       operand_b,
    input  logic [1:0]        mode,
    output fpm_pkg::fpm_unp_t unp
);
    import fpm_pkg::*;

    logic       a_max, b_max, a_zero, b_zero, a_nan, b_nan, a_inf, b_inf, sign;
    logic [7:0] ea, eb;

    always_comb begin
        ea     = operand_a[30:23];
        eb     = operand_b[30:23];
        sign   = operand_a[31] ^ operand_b[31];
        a_max  = (ea == 8'hff);
        b_max  = (eb == 8'hff);
        a_nan  = a_max && (operand_a[22:0] != 23'd0);
        b_nan  = b_max && (operand_b[22:0] != 23'd0);
        a_inf  = a_max && (operand_a[22:0] == 23'd0);
        b_inf  = b_max && (operand_b[22:0] == 23'd0);
        a_zero = (operand_a[30:0] == 31'd0);
        b_zero = (operand_b[30:0] == 31'd0);

        unp.special     = 1'b1;
        unp.special_val = {sign, 31'd0};
        if (a_nan) begin
            unp.special_val = operand_a | QUIET_BIT;
        end else if (b_nan) begin
            unp.special_val = operand_b | QUIET_BIT;
        end else if ((a_zero && b_inf) || (b_zero && a_inf)) begin
            unp.special_val = DEFAULT_NAN;
        end else if (a_inf || b_inf) begin
            unp.special_val = {sign, INF_MAG};
        end else if (a_zero || b_zero) begin
            unp.special_val = {sign, 31'd0};
        end else begin
            unp.special = 1'b0;
        end

        unp.sign    = sign;
        unp.sig_a   = {(ea != 8'd0), operand_a[22:0]};
        unp.sig_b   = {(eb != 8'd0), operand_b[22:0]};
        unp.exp_sum = $signed({2'b00, (ea == 8'd0) ? 8'd1 : ea})
                    + $signed({2'b00, (eb == 8'd0) ? 8'd1 : eb}) - 10'sd127;
        unp.mode    = mode;
    end

endmodule

// File: rtl/core/fpm_normalize.sv
module fpm_normalize (
    input  fpm_pkg::fpm_mul_t mul,
    output fpm_pkg::fpm_nrm_t nrm
);
    import fpm_pkg::*;

    logic [5:0]         lead;
    logic [47:0]        norm;
    logic signed [10:0] e;
    logic [5:0]         sh;
    logic [47:0]        den;
    logic               sticky;

    always_comb begin
        lead = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (mul.prod[i]) begin
                lead = 6'(i);
            end
        end
        norm = mul.prod << (6'd47 - lead);
        e    = 11'(mul.exp_sum) + 11'($signed({5'd0, lead})) - 11'sd46;
        sh   = 6'd0;
        if (e < 11'sd1) begin
            sh = (e < -11'sd49) ? 6'd50 : 6'(11'sd1 - e);
        end
        sticky = ((norm & ((48'd1 << sh) - 48'd1)) != 48'd0);
        den    = (sh >= 6'd48) ? 48'd0 : (norm >> sh);
        den[0] = den[0] | sticky;

        nrm.special     = mul.special;
        nrm.special_val = mul.special_val;
        nrm.sign        = mul.sign;
        nrm.mode        = mul.mode;
        nrm.ovf         = (e > 11'sd254);
        nrm.exp_field   = (e < 11'sd1) ? 8'd0 : 8'(e - 11'sd1);
        nrm.kept        = den[47:24];
        nrm.rem         = den[23:0];
    end

endmodule

// File: rtl/core/fpm_round.sv
module fpm_round (
    input  fpm_pkg::fpm_nrm_t nrm,
    output logic [31:0]       result
);
    import fpm_pkg::*;

    logic        inc;
    logic [31:0] bits;

    always_comb begin
        case (nrm.mode)
            RND_NEAREST_EVEN: inc = (nrm.rem > 24'h800000)
                                 || ((nrm.rem == 24'h800000) && nrm.kept[0]);
            RND_TOWARD_ZERO:  inc = 1'b0;
            RND_TOWARD_POS:   inc = ~nrm.sign && (nrm.rem != 24'd0);
            RND_TOWARD_NEG:   inc = nrm.sign && (nrm.rem != 24'd0);
            default:          inc = 1'b0;
        endcase
        bits = {1'b0, nrm.exp_field, 23'd0} + {8'd0, nrm.kept} + {31'd0, inc};
        if (nrm.special) begin
            result = nrm.special_val;
        end else if (nrm.ovf || (bits >= 32'h7f800000)) begin
            result = fpm_overflow(nrm.sign, nrm.mode);
        end else begin
            result = {nrm.sign, bits[30:0]};
        end
    end

endmodule
